// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Concurrent check clocked on the rising edge, quiet while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg
// Types and constants of the streaming decimal-to-int32 parser.
// ----------------------------------------------------------------------------
package dip_pkg;

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;

    // Largest magnitude that still takes a further digit, up to LAST_DIGIT_MAX
    localparam logic [30:0] MAG_GUARD      = 31'd214748364;
    localparam logic [3:0]  LAST_DIGIT_MAX = 4'd7;

    // Saturated results for positive and negative overflow
    localparam logic [31:0] SAT_POS_VALUE = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG_VALUE = 32'h8000_0000;

    localparam int OUT_COUNT_BITS = 16;

    typedef struct packed {
        logic        active;
        logic        negative;
        logic [30:0] magnitude;
        logic        overflow;
        logic        digit_seen;
    } parse_state_t;

    typedef struct packed {
        logic [31:0]               value;
        logic [OUT_COUNT_BITS-1:0] count;
        logic                      digits;
        logic                      saturated;
    } parse_result_t;

endpackage

// File: rtl/dip_in_if.sv
// ----------------------------------------------------------------------------
// dip_in_if
// Character channel: one ASCII byte and a start-of-number flag per transfer.
// ----------------------------------------------------------------------------
interface dip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       start_flag;

    modport source (output valid, output character, output start_flag, input ready);
    modport sink   (input valid, input character, input start_flag, output ready);
endinterface

// File: rtl/dip_out_if.sv
// ----------------------------------------------------------------------------
// dip_out_if
// Result channel: one parsed integer with count and status per transfer.
// ----------------------------------------------------------------------------
interface dip_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] parsed_value;
    logic [15:0]        consumed_count;
    logic               digits_found;
    logic               was_saturated;

    modport source (output valid, output parsed_value, output consumed_count,
                    output digits_found, output was_saturated, input ready);
    modport sink   (input valid, input parsed_value, input consumed_count,
                    input digits_found, input was_saturated, output ready);
endinterface

// File: rtl/decimal_int_parser_saturating.sv
// ----------------------------------------------------------------------------
// decimal_int_parser_saturating
// Streaming ASCII decimal to saturating int32 parser.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  --------+-----+-------------------------------------------------+----------
//  din     | in  | character[8], start_flag[1]                     | valid/ready
//  dout    | out | parsed_value[32], consumed_count[16],           | valid/ready
//          |     | digits_found[1], was_saturated[1]               |
//
//  One character per cycle. A character is registered on transfer, then
//  stepped through the parse state once the result slot is free or being
//  drained, and a finished number lands in the result register at that edge.
//  The parse-state loop is one step wide, so a new character may follow
//  every cycle. rst_n clears the parse state and both valid flags at once.
//  The input stage stalls only while a result is held and dout.ready is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_int_parser_saturating #(
    parameter int COUNT_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    dip_in_if.sink     din,
    dip_out_if.source  dout
);
    import dip_pkg::*;

    logic                  in_valid_reg;
    logic [7:0]            in_char_reg;
    logic                  in_start_reg;

    parse_state_t          state_reg;
    parse_state_t          state_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    logic                  out_valid_reg;
    parse_result_t         out_res_reg;

    logic                  emit;
    parse_result_t         result;
    logic                  advance;
    logic                  step;

    // the step stage moves whenever the result slot is free or being drained
    assign advance  = !out_valid_reg || dout.ready;
    assign step     = in_valid_reg && advance;
    assign din.ready = !in_valid_reg || advance;

    dip_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .cur_state  (state_reg),
        .cur_count  (count_reg),
        .character  (in_char_reg),
        .start_flag (in_start_reg),
        .next_state (state_next),
        .next_count (count_next),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (din.ready)
                in_valid_reg <= din.valid;
            if (step)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (advance)
                out_valid_reg <= step && emit;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (din.valid && din.ready)
        begin
            in_char_reg  <= din.character;
            in_start_reg <= din.start_flag;
        end
        if (step && emit)
            out_res_reg <= result;
    end

    assign dout.valid          = out_valid_reg;
    assign dout.parsed_value   = out_res_reg.value;
    assign dout.consumed_count = out_res_reg.count;
    assign dout.digits_found   = out_res_reg.digits;
    assign dout.was_saturated  = out_res_reg.saturated;

    `ASSERT_CLK(a_empty_result_zero, clk, rst_n,
        (out_valid_reg && !out_res_reg.digits) |->
            (out_res_reg.value == 32'd0 && out_res_reg.count == '0 && !out_res_reg.saturated),
        "result without digits is not all zero")
    `ASSERT_CLK(a_sat_value_limit, clk, rst_n,
        (out_valid_reg && out_res_reg.saturated) |->
            (out_res_reg.value == SAT_POS_VALUE || out_res_reg.value == SAT_NEG_VALUE),
        "saturated result is not an int32 limit")
    `ASSERT_NEVER(a_sat_without_digit, clk, rst_n,
        out_valid_reg && out_res_reg.saturated && !out_res_reg.digits,
        "saturation flagged with no digit seen")
    `ASSERT_NEVER(a_digit_zero_count, clk, rst_n,
        out_valid_reg && out_res_reg.digits && out_res_reg.count == '0,
        "digits found but consumed count is zero")
    `ASSERT_CLK(a_idle_state_clear, clk, rst_n,
        !state_reg.active |->
            (state_reg.magnitude == '0 && !state_reg.digit_seen && !state_reg.overflow
             && count_reg == '0),
        "idle parser holds leftover state")

endmodule

// File: rtl/dip_step.sv
// ----------------------------------------------------------------------------
// dip_step
// One character step: next parse state, next count and the finished result.
// ----------------------------------------------------------------------------
module dip_step #(
    parameter int COUNT_BITS = 16
) (
    input  dip_pkg::parse_state_t  cur_state,
    input  logic [COUNT_BITS-1:0]  cur_count,
    input  logic [7:0]             character,
    input  logic                   start_flag,
    output dip_pkg::parse_state_t  next_state,
    output logic [COUNT_BITS-1:0]  next_count,
    output logic                   emit,
    output dip_pkg::parse_result_t result
);
    import dip_pkg::*;

    localparam longint unsigned CountLimit = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint unsigned CountCap   = (CountLimit > 64'd65535) ? 64'd65535 : CountLimit;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(CountCap);

    logic        is_digit;
    logic        is_sign;
    logic [3:0]  digit;
    logic        guard_trip;
    logic [30:0] mag_times_ten;

    assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    assign is_sign  = (character == CHAR_PLUS) || (character == CHAR_MINUS);
    assign digit    = character[3:0];

    // x*10 = x*8 + x*2, kept to 31 bits
    assign mag_times_ten = {cur_state.magnitude[27:0], 3'b000}
                         + {cur_state.magnitude[29:0], 1'b0};

    always_comb
    begin
        parse_state_t st;
        logic [COUNT_BITS-1:0] cnt;
        logic go;

        st     = cur_state;
        cnt    = cur_count;
        go     = cur_state.active;
        emit   = 1'b0;
        result = '0;

        if (start_flag)
        begin
            // abandon whatever was in flight
            st        = '0;
            cnt       = '0;
            st.active = 1'b1;
            go        = 1'b1;
            if (is_sign)
            begin
                st.negative = (character == CHAR_MINUS);
                cnt         = (cnt != COUNT_MAX) ? cnt + 1'b1 : cnt;
                go          = 1'b0;
            end
        end

        guard_trip = (st.magnitude > MAG_GUARD)
                   || ((st.magnitude == MAG_GUARD) && (digit > LAST_DIGIT_MAX));

        if (go)
        begin
            if (is_digit)
            begin
                if (!st.overflow)
                begin
                    if (guard_trip)
                        st.overflow = 1'b1;
                    else
                        st.magnitude = (start_flag ? 31'd0 : mag_times_ten) + 31'(digit);
                end
                st.digit_seen = 1'b1;
                cnt = (cnt != COUNT_MAX) ? cnt + 1'b1 : cnt;
            end
            else
            begin
                emit = 1'b1;
                if (st.digit_seen)
                begin
                    if (st.overflow)
                        result.value = st.negative ? SAT_NEG_VALUE : SAT_POS_VALUE;
                    else
                        result.value = st.negative ? 32'd0 - {1'b0, st.magnitude}
                                                   : {1'b0, st.magnitude};
                    result.count     = OUT_COUNT_BITS'(cnt);
                    result.digits    = 1'b1;
                    result.saturated = st.overflow;
                end
                st  = '0;
                cnt = '0;
            end
        end

        next_state = st;
        next_count = cnt;
    end

endmodule

// File: dv/decimal_int_parser_saturating_tb.sv
// ----------------------------------------------------------------------------
// decimal_int_parser_saturating_tb
// Self-checking bench for the streaming ASCII-to-int32 parser. A directed
// table covers the sign and terminator corners and the int32 minimum. Random
// numbers follow, many of them close to the overflow boundary. Both
// channels idle at random, and the result side holds off once long enough
// to back up the input. Every result is compared against the table's own
// expectation or an in-bench parse model.
// ----------------------------------------------------------------------------
module decimal_int_parser_saturating_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dip_pkg::*;

    localparam int     COUNT_BITS     = 16;
    localparam longint COUNT_LIMIT    = (64'd1 << COUNT_BITS) - 1;
    localparam longint COUNT_CAP      = (COUNT_LIMIT > 65535) ? 65535 : COUNT_LIMIT;
    localparam int     RANDOM_CHARS   = 500;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     DRAIN_CYCLES   = 8;
    localparam int     MAX_REPORTS    = 10;

    typedef struct {
        logic [7:0]    ch;
        logic          st;
        bit            typed;
        parse_result_t want;
    } char_row_t;

    logic clk;
    logic rst_n;

    dip_in_if  din ();
    dip_out_if dout ();

    decimal_int_parser_saturating #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    // Parse model state
    logic        pm_active;
    logic        pm_negative;
    logic [30:0] pm_magnitude;
    logic        pm_overflow;
    logic        pm_digit_seen;
    logic [15:0] pm_count;

    parse_result_t expected_numbers[$];
    char_row_t     directed_rows[$];

    int  parse_chars;
    int  numbers_checked = 0;
    int  saturated_seen  = 0;
    int  empty_seen      = 0;
    int  mismatches      = 0;
    int  fail_count      = 0;
    int  idle_cycles     = 0;
    bit  tx_burst;
    bit  hold_request    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_nondigit();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 20)
            return ($urandom_range(0, 1) != 0) ? CHAR_PLUS : CHAR_MINUS;
        do
            c = 8'($urandom_range(0, 255));
        while (c >= CHAR_ZERO && c <= CHAR_NINE);
        return c;
    endfunction

    function automatic void clear_number();
        pm_active     = 1'b0;
        pm_negative   = 1'b0;
        pm_magnitude  = '0;
        pm_overflow   = 1'b0;
        pm_digit_seen = 1'b0;
        pm_count      = '0;
    endfunction

    function automatic void bump_count();
        if (longint'(pm_count) < COUNT_CAP)
            pm_count = pm_count + 16'd1;
    endfunction

    // Advance the parse by one character; return 1 when a number completes.
    function automatic bit parse_char(input logic [7:0] ch, input logic st,
                                      output parse_result_t res);
        logic [3:0] d;
        res = '0;
        if (st)
        begin
            clear_number();
            pm_active = 1'b1;
            if (ch == CHAR_PLUS || ch == CHAR_MINUS)
            begin
                pm_negative = (ch == CHAR_MINUS);
                bump_count();
                return 1'b0;
            end
        end
        else if (!pm_active)
            return 1'b0;

        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            d = 4'(ch - CHAR_ZERO);
            if (!pm_overflow)
            begin
                if (pm_magnitude > MAG_GUARD ||
                    (pm_magnitude == MAG_GUARD && d > LAST_DIGIT_MAX))
                    pm_overflow = 1'b1;
                else
                    pm_magnitude = 31'(pm_magnitude * 10 + d);
            end
            pm_digit_seen = 1'b1;
            bump_count();
            return 1'b0;
        end

        // Any other character ends the number without being consumed
        if (pm_digit_seen)
        begin
            if (pm_overflow)
                res.value = pm_negative ? SAT_NEG_VALUE : SAT_POS_VALUE;
            else
                res.value = pm_negative ? -{1'b0, pm_magnitude} : {1'b0, pm_magnitude};
            res.count     = pm_count;
            res.digits    = 1'b1;
            res.saturated = pm_overflow;
        end
        clear_number();
        return 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic st,
                             input bit typed, input parse_result_t want);
        int            gap;
        bit            done;
        parse_result_t res;
        gap = pick_gap(tx_burst);
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid      <= 1'b1;
        din.character  <= ch;
        din.start_flag <= st;
        do
            @(posedge clk);
        while (!din.ready);
        if (st || pm_active)
            parse_chars++;
        done = parse_char(ch, st, res);
        if (typed)
            expected_numbers.push_back(want);
        else if (done)
            expected_numbers.push_back(res);
    endtask

    task automatic add_row(input logic [7:0] ch, input logic st,
                           input bit typed, input parse_result_t want);
        char_row_t row;
        row.ch    = ch;
        row.st    = st;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Optional sign, a random run of digits (often near the int32 limit),
    // usually a terminator, sometimes trailing noise.
    task automatic send_number();
        int         sign_pick;
        int         len_pick;
        int         n_digits;
        bit         near;
        bit         first;
        logic [7:0] ch;
        string      limit_digits;
        limit_digits = "2147483648";
        near         = 1'b0;
        first        = 1'b1;
        tx_burst     = ($urandom_range(0, 9) == 0);
        sign_pick    = $urandom_range(0, 99);
        len_pick     = $urandom_range(0, 99);
        if (len_pick < 40)
            n_digits = $urandom_range(1, 4);
        else if (len_pick < 65)
            n_digits = $urandom_range(5, 9);
        else if (len_pick < 85)
        begin
            n_digits = $urandom_range(10, 11);
            near     = 1'b1;
        end
        else if (len_pick < 95)
            n_digits = $urandom_range(12, 25);
        else
            n_digits = 0;

        if (sign_pick < 20)
        begin
            send_char(CHAR_MINUS, 1'b1, 1'b0, '0);
            first = 1'b0;
        end
        else if (sign_pick < 32)
        begin
            send_char(CHAR_PLUS, 1'b1, 1'b0, '0);
            first = 1'b0;
        end

        for (int i = 0; i < n_digits; i++)
        begin
            ch = CHAR_ZERO + 8'($urandom_range(0, 9));
            if (near && i < 9 && $urandom_range(0, 9) != 0)
                ch = limit_digits[i];
            else if (near && i == 9)
                ch = CHAR_ZERO + 8'($urandom_range(6, 9));
            send_char(ch, first, 1'b0, '0);
            first = 1'b0;
        end

        if ($urandom_range(0, 99) < 88)
            send_char(pick_nondigit(), first, 1'b0, '0);
        if ($urandom_range(0, 99) < 25)
            repeat ($urandom_range(1, 3))
                send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
    endtask

    // Result side: random stalls, plus one long hold when requested
    initial
    begin
        int gap;
        dout.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                dout.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                gap = pick_gap($urandom_range(0, 7) == 0);
                if (gap > 0)
                begin
                    dout.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                dout.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each transfer on the result channel with the oldest expectation
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && dout.valid && dout.ready)
        begin
            if (expected_numbers.size() == 0)
            begin
                fail_count++;
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: value %0d count %0d digits %0b sat %0b",
                             dout.parsed_value, dout.consumed_count,
                             dout.digits_found, dout.was_saturated);
                mismatches++;
            end
            else
            begin
                want = expected_numbers.pop_front();
                numbers_checked++;
                if (want.saturated)
                    saturated_seen++;
                if (!want.digits)
                    empty_seen++;
                if (dout.parsed_value !== want.value || dout.consumed_count !== want.count ||
                    dout.digits_found !== want.digits ||
                    dout.was_saturated !== want.saturated)
                begin
                    fail_count++;
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch %0t: val %0d/%0d cnt %0d/%0d dig %0b/%0b sat %0b/%0b",
                                 $realtime, $signed(want.value), dout.parsed_value,
                                 want.count, dout.consumed_count, want.digits,
                                 dout.digits_found, want.saturated, dout.was_saturated);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((din.valid && din.ready) || (dout.valid && dout.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_numbers.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        string      limit_digits;
        char_row_t  row;
        bit         pressure_done;
        rst_n           <= 1'b0;
        din.valid       <= 1'b0;
        din.character   <= '0;
        din.start_flag  <= 1'b0;
        tx_burst        = 1'b0;
        pressure_done   = 1'b0;
        parse_chars     = 0;
        limit_digits    = "2147483648";
        clear_number();

        // Idle character, sign only with a sign-not-first terminator
        add_row("x", 1'b0, 1'b0, '0);
        add_row(CHAR_MINUS, 1'b1, 1'b0, '0);
        add_row(CHAR_PLUS, 1'b0, 1'b1, {32'h0, 16'd0, 1'b0, 1'b0});
        // Negative zero, ended by the byte just below '0'
        add_row(CHAR_MINUS, 1'b1, 1'b0, '0);
        add_row(CHAR_ZERO, 1'b0, 1'b0, '0);
        add_row("/", 1'b0, 1'b1, {32'h0, 16'd2, 1'b1, 1'b0});
        // A new start abandons the unfinished number
        add_row("7", 1'b1, 1'b0, '0);
        add_row(CHAR_NINE, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b1, {32'd9, 16'd1, 1'b1, 1'b0});
        // Non-digit as the start character
        add_row(8'h00, 1'b1, 1'b1, {32'h0, 16'd0, 1'b0, 1'b0});
        // Exact int32 minimum saturates
        add_row(CHAR_MINUS, 1'b1, 1'b0, '0);
        for (int i = 0; i < 10; i++)
            add_row(limit_digits[i], 1'b0, 1'b0, '0);
        add_row(" ", 1'b0, 1'b1, {SAT_NEG_VALUE, 16'd11, 1'b1, 1'b1});
        // Explicit plus, ended by the byte just above '9'
        add_row(CHAR_PLUS, 1'b1, 1'b0, '0);
        add_row("5", 1'b0, 1'b0, '0);
        add_row(":", 1'b0, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_char(row.ch, row.st, row.typed, row.want);
        end

        while (parse_chars < RANDOM_CHARS)
        begin
            // Stall the result side once, mid-run, while characters keep coming
            if (!pressure_done && parse_chars > RANDOM_CHARS / 3)
            begin
                hold_request  = 1'b1;
                pressure_done = 1'b1;
            end
            send_number();
        end
        din.valid <= 1'b0;

        while (expected_numbers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d parsed characters; checked %0d numbers: %0d saturated,",
                 parse_chars, numbers_checked, saturated_seen);
        $display("%0d without digits; %0d errors", empty_seen, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
